FILE: rtl/blpk_pkg.sv
// Shared types, codes and sizes for the button long-press and knob event unit.
package blpk_pkg;

  localparam int BUTTONS = 16;
  localparam int KNOBS   = 4;
  localparam int MAX_OUT = 16;

  localparam int BTN_IW = $clog2(BUTTONS);
  localparam int KNB_IW = $clog2(KNOBS);
  localparam int CNT_W  = $clog2(MAX_OUT + 1);

  // input kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_KNOB   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // button phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_LONG    = 2'd2;

  // event kinds
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_LONG    = 2'd2;
  localparam logic [1:0] EV_KNOB    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_BTN_MASK   = 2'd1;
  localparam logic [1:0] REG_KNOB_MASK  = 2'd2;

  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [15:0] BTN_MASK_RST   = 16'hFFFF;
  localparam logic [3:0]  KNOB_MASK_RST  = 4'hF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         button_index;
    logic               pressed;
    logic [1:0]         knob_index;
    logic signed [15:0] knob_position;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [3:0]        unit_index;
    logic signed [7:0] knob_delta;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] press_time;
  } btn_entry_t;

endpackage

FILE: rtl/button_long_press_and_knob_events_unit.sv
// Top level of the button long-press and knob event unit.
// Use: items enter on in_valid/in_ready, events leave on out_valid/out_ready,
// registers are written on cfg_valid/cfg_ready (cfg_ready is always high).
// One item is worked at a time; in_ready is high only while the sequencer idles.
// Button edge and knob items first read the state memory, then update it
// and load the output register. A tick scan reads one button entry per
// cycle unless a found event waits on a full output; the last
// long-press event is held back one step so its last flag can be set.
// Items that cause no event through a repeated edge or a zero knob move
// pass the same states; disabled units and unused kinds finish at once.
// The per-unit state sits in two RAMs with registered reads; valid bits per
// entry make unwritten entries read as idle / zero right after reset.
// Reset: registers return to threshold 500 and all-ones masks and the valid
// bits clear, so no memory sweep is needed.
// Stall: the output register holds an event until taken; when a new event
// is due while it is still full, the sequencer waits in place.
module button_long_press_and_knob_events_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  blpk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output blpk_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BTN   = 5'b00010,
    S_KNOB  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [15:0] long_press_ms;
  logic [15:0] button_enable_mask;
  logic [3:0]  knob_enable_mask;

  blpk_pkg::in_item_t item;

  // button memory
  logic                             b_we, b_re;
  logic [blpk_pkg::BTN_IW-1:0]      b_waddr, b_raddr;
  blpk_pkg::btn_entry_t             b_wdata, b_rdata, b_cur;
  logic [blpk_pkg::BUTTONS-1:0]     b_valid;
  logic                             b_rdv;

  // knob memory
  logic                             k_we, k_re;
  logic [blpk_pkg::KNB_IW-1:0]      k_waddr, k_raddr;
  logic [15:0]                      k_wdata, k_rdata, k_cur;
  logic [blpk_pkg::KNOBS-1:0]       k_valid;
  logic                             k_rdv;

  logic [blpk_pkg::BTN_IW-1:0]      scan_idx, scan_idx_next;
  logic [blpk_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic                             pend_v, pend_v_next;
  logic [blpk_pkg::BTN_IW-1:0]      pend_idx, pend_idx_next;

  logic                             out_load, out_free;
  blpk_pkg::out_item_t              out_ev;

  logic [31:0]                      elapsed;
  logic [15:0]                      diff;
  logic                             qual;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms      <= blpk_pkg::LONG_PRESS_RST;
      button_enable_mask <= blpk_pkg::BTN_MASK_RST;
      knob_enable_mask   <= blpk_pkg::KNOB_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        blpk_pkg::REG_LONG_PRESS: long_press_ms      <= cfg_data;
        blpk_pkg::REG_BTN_MASK:   button_enable_mask <= cfg_data;
        blpk_pkg::REG_KNOB_MASK:  knob_enable_mask   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  blpk_ram #(
    .WIDTH($bits(blpk_pkg::btn_entry_t)),
    .DEPTH(blpk_pkg::BUTTONS)
  ) u_btn_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .re   (b_re),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  blpk_ram #(
    .WIDTH(16),
    .DEPTH(blpk_pkg::KNOBS)
  ) u_knob_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(k_waddr),
    .wdata(k_wdata),
    .re   (k_re),
    .raddr(k_raddr),
    .rdata(k_rdata)
  );

  // valid bits stand in for the reset contents of the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= '0;
      k_valid <= '0;
    end else begin
      if (b_we) b_valid[b_waddr] <= 1'b1;
      if (k_we) k_valid[k_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_re) b_rdv <= b_valid[b_raddr];
    if (k_re) k_rdv <= k_valid[k_raddr];
  end

  always_comb begin
    b_cur = b_rdata;
    if (!b_rdv) begin
      b_cur.phase      = blpk_pkg::PH_IDLE;
      b_cur.press_time = '0;
    end
  end

  assign k_cur   = k_rdv ? k_rdata : 16'd0;
  assign diff    = item.knob_position - k_cur;
  assign elapsed = item.time_ms - b_cur.press_time;
  assign qual    = button_enable_mask[scan_idx] && (b_cur.phase == blpk_pkg::PH_PRESSED) &&
                   (elapsed >= {16'd0, long_press_ms});

  always_comb begin
    logic ev_need;
    logic done;
    ev_need       = 1'b0;
    done          = 1'b0;
    state_next    = state;
    b_we          = 1'b0;
    b_waddr       = item.button_index;
    b_wdata       = b_cur;
    b_re          = 1'b0;
    b_raddr       = in_data.button_index;
    k_we          = 1'b0;
    k_waddr       = item.knob_index;
    k_wdata       = item.knob_position;
    k_re          = 1'b0;
    k_raddr       = in_data.knob_index;
    scan_idx_next = scan_idx;
    cnt_next      = cnt;
    pend_v_next   = pend_v;
    pend_idx_next = pend_idx;
    out_load      = 1'b0;
    out_ev        = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            blpk_pkg::KIND_BUTTON: begin
              if (button_enable_mask[in_data.button_index]) begin
                b_re       = 1'b1;
                state_next = S_BTN;
              end
            end
            blpk_pkg::KIND_KNOB: begin
              if (knob_enable_mask[in_data.knob_index]) begin
                k_re       = 1'b1;
                state_next = S_KNOB;
              end
            end
            blpk_pkg::KIND_TICK: begin
              b_re          = 1'b1;
              b_raddr       = '0;
              scan_idx_next = '0;
              cnt_next      = '0;
              pend_v_next   = 1'b0;
              state_next    = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_BTN: begin
        out_ev.unit_index = item.button_index;
        out_ev.last       = 1'b1;
        if (item.pressed && b_cur.phase == blpk_pkg::PH_IDLE) begin
          ev_need            = 1'b1;
          out_ev.event_kind  = blpk_pkg::EV_PRESS;
          b_wdata.phase      = blpk_pkg::PH_PRESSED;
          b_wdata.press_time = item.time_ms;
        end else if (!item.pressed && (b_cur.phase == blpk_pkg::PH_PRESSED ||
                                       b_cur.phase == blpk_pkg::PH_LONG)) begin
          ev_need           = 1'b1;
          out_ev.event_kind = blpk_pkg::EV_RELEASE;
          b_wdata.phase     = blpk_pkg::PH_IDLE;
        end
        if (!ev_need) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          b_we       = 1'b1;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_KNOB: begin
        out_ev.event_kind = blpk_pkg::EV_KNOB;
        out_ev.unit_index = {2'b00, item.knob_index};
        out_ev.knob_delta = $signed(diff[7:0]);
        out_ev.last       = 1'b1;
        if (diff == 16'd0 || out_free) begin
          k_we       = 1'b1;
          out_load   = (diff != 16'd0);
          state_next = S_IDLE;
        end
      end

      S_SCAN: begin
        // a found event pushes the held-back one out; wait if the output is full
        out_ev.event_kind = blpk_pkg::EV_LONG;
        out_ev.unit_index = pend_idx;
        if (!(qual && pend_v && !out_free)) begin
          if (qual) begin
            b_we          = 1'b1;
            b_waddr       = scan_idx;
            b_wdata.phase = blpk_pkg::PH_LONG;
            out_load      = pend_v;
            pend_v_next   = 1'b1;
            pend_idx_next = scan_idx;
            cnt_next      = cnt + 1'b1;
          end
          done = (scan_idx == blpk_pkg::BTN_IW'(blpk_pkg::BUTTONS - 1)) ||
                 (cnt_next == blpk_pkg::CNT_W'(blpk_pkg::MAX_OUT));
          if (done) begin
            state_next = S_FLUSH;
          end else begin
            scan_idx_next = scan_idx + 1'b1;
            b_re          = 1'b1;
            b_raddr       = scan_idx + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        out_ev.event_kind = blpk_pkg::EV_LONG;
        out_ev.unit_index = pend_idx;
        out_ev.last       = 1'b1;
        if (!pend_v) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load    = 1'b1;
          pend_v_next = 1'b0;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
      cnt      <= '0;
      pend_v   <= 1'b0;
      pend_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      cnt      <= cnt_next;
      pend_v   <= pend_v_next;
      pend_idx <= pend_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_ev;
  end

endmodule

FILE: rtl/blpk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blpk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the button long-press and knob event unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 40;

  // Mirrors the unit's per-button / per-knob state and queues the events it should emit.
  class event_scoreboard;
    logic [1:0]          phase     [blpk_pkg::BUTTONS];
    logic [31:0]         press_at  [blpk_pkg::BUTTONS];
    logic [15:0]         knob_last [blpk_pkg::KNOBS];
    logic [15:0]         hold_ms;
    logic [15:0]         btn_mask;
    logic [3:0]          knob_mask;
    blpk_pkg::out_item_t pending[$];
    int                  errors;

    function new();
      for (int i = 0; i < blpk_pkg::BUTTONS; i++) begin
        phase[i]    = blpk_pkg::PH_IDLE;
        press_at[i] = '0;
      end
      for (int i = 0; i < blpk_pkg::KNOBS; i++) knob_last[i] = '0;
      hold_ms   = blpk_pkg::LONG_PRESS_RST;
      btn_mask  = blpk_pkg::BTN_MASK_RST;
      knob_mask = blpk_pkg::KNOB_MASK_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        blpk_pkg::REG_LONG_PRESS: hold_ms   = val;
        blpk_pkg::REG_BTN_MASK:   btn_mask  = val;
        blpk_pkg::REG_KNOB_MASK:  knob_mask = val[3:0];
        default: ;
      endcase
    endfunction

    function void push_event(logic [1:0] kind, logic [3:0] unit, logic [7:0] delta);
      blpk_pkg::out_item_t e;
      e.event_kind = kind;
      e.unit_index = unit;
      e.knob_delta = delta;
      e.last       = 1'b0;
      pending.push_back(e);
    endfunction

    function void note_input(blpk_pkg::in_item_t it);
      int                  start;
      int                  n;
      logic [15:0]         diff;
      blpk_pkg::out_item_t e;
      start = pending.size();
      case (it.kind)
        blpk_pkg::KIND_BUTTON: begin
          if (btn_mask[it.button_index]) begin
            if (it.pressed) begin
              if (phase[it.button_index] == blpk_pkg::PH_IDLE) begin
                phase[it.button_index]    = blpk_pkg::PH_PRESSED;
                press_at[it.button_index] = it.time_ms;
                push_event(blpk_pkg::EV_PRESS, it.button_index, 8'd0);
              end
            end else if (phase[it.button_index] == blpk_pkg::PH_PRESSED ||
                         phase[it.button_index] == blpk_pkg::PH_LONG) begin
              phase[it.button_index] = blpk_pkg::PH_IDLE;
              push_event(blpk_pkg::EV_RELEASE, it.button_index, 8'd0);
            end
          end
        end
        blpk_pkg::KIND_KNOB: begin
          if (knob_mask[it.knob_index]) begin
            diff = it.knob_position - knob_last[it.knob_index];
            knob_last[it.knob_index] = it.knob_position;
            if (diff != 16'd0)
              push_event(blpk_pkg::EV_KNOB, {2'b00, it.knob_index}, diff[7:0]);
          end
        end
        blpk_pkg::KIND_TICK: begin
          for (int i = 0; i < blpk_pkg::BUTTONS; i++) begin
            if (pending.size() - start < blpk_pkg::MAX_OUT && btn_mask[i] &&
                phase[i] == blpk_pkg::PH_PRESSED &&
                (it.time_ms - press_at[i]) >= {16'd0, hold_ms}) begin
              phase[i] = blpk_pkg::PH_LONG;
              push_event(blpk_pkg::EV_LONG, 4'(i), 8'd0);
            end
          end
        end
        default: ;
      endcase
      n = pending.size() - start;
      if (n > 0) begin
        e = pending.pop_back();
        e.last = 1'b1;
        pending.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(blpk_pkg::out_item_t got);
      blpk_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event kind=%0d unit=%0d delta=%0d last=%0d",
                         got.event_kind, got.unit_index, got.knob_delta, got.last));
      end else begin
        want = pending.pop_front();
        if (got.event_kind !== want.event_kind || got.unit_index !== want.unit_index ||
            got.knob_delta !== want.knob_delta || got.last !== want.last)
          report($sformatf("got kind=%0d unit=%0d delta=%0d last=%0d, want %0d/%0d/%0d/%0d",
                           got.event_kind, got.unit_index, got.knob_delta, got.last,
                           want.event_kind, want.unit_index, want.knob_delta, want.last));
      end
    endtask

    task check_leftover();
      if (pending.size() != 0)
        report($sformatf("%0d expected events never arrived", pending.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  blpk_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  blpk_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_data;

  event_scoreboard sb;
  int          send_idle_pct;
  int          stall_pct;
  int          cycles;
  logic [31:0] now_ms;

  button_long_press_and_knob_events_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL button_long_press_and_knob_events_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // both channels sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic blpk_pkg::in_item_t mk(logic [1:0] kind, logic [3:0] bidx, logic down,
                                            logic [1:0] kidx, logic [15:0] pos,
                                            logic [31:0] t);
    blpk_pkg::in_item_t it;
    it.kind          = kind;
    it.button_index  = bidx;
    it.pressed       = down;
    it.knob_index    = kidx;
    it.knob_position = pos;
    it.time_ms       = t;
    return it;
  endfunction

  function automatic blpk_pkg::in_item_t rand_item();
    blpk_pkg::in_item_t it;
    int                 sel;
    logic [15:0]        base;
    it       = blpk_pkg::in_item_t'({$urandom, $urandom});
    sel      = $urandom_range(99);
    if (sel < 40) begin
      it.kind = blpk_pkg::KIND_BUTTON;
      if ($urandom_range(99) < 80)
        it.pressed = (sb.phase[it.button_index] == blpk_pkg::PH_IDLE);
      now_ms = now_ms + $urandom_range(0, 50);
      it.time_ms = now_ms;
    end else if (sel < 70) begin
      it.kind = blpk_pkg::KIND_KNOB;
      base = sb.knob_last[it.knob_index];
      sel  = $urandom_range(99);
      if (sel < 60)      it.knob_position = base + 16'($urandom_range(0, 400)) - 16'd200;
      else if (sel < 75) it.knob_position = base + (16'($urandom_range(1, 255)) << 8);
    end else if (sel < 95) begin
      it.kind = blpk_pkg::KIND_TICK;
      if ($urandom_range(99) < 10) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, int'(sb.hold_ms) * 2 + 4);
      it.time_ms = now_ms;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task send(blpk_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // items without events may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task setup(logic [15:0] hold, logic [15:0] bmask, logic [3:0] kmask, int idle, int stall);
    wait_quiet();
    write_reg(blpk_pkg::REG_LONG_PRESS, hold);
    write_reg(blpk_pkg::REG_BTN_MASK, bmask);
    write_reg(blpk_pkg::REG_KNOB_MASK, {12'd0, kmask});
    cfg_valid     <= 1'b0;
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  task run_random(int want, int max_raw);
    blpk_pkg::in_item_t it;
    int                 counted;
    int                 raw;
    counted = 0;
    raw     = 0;
    while (counted < want && raw < max_raw) begin
      it = rand_item();
      raw++;
      // ignored items do not count
      if ((it.kind == blpk_pkg::KIND_BUTTON && sb.btn_mask[it.button_index]) ||
          (it.kind == blpk_pkg::KIND_KNOB && sb.knob_mask[it.knob_index]) ||
          it.kind == blpk_pkg::KIND_TICK)
        counted++;
      send(it);
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    now_ms        = 32'h100;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges, repeats, threshold boundary, knob wrap and coarse move
    send(mk(blpk_pkg::KIND_BUTTON, 4'd0, 1'b1, 2'd0, 16'd0, 32'd0));
    send(mk(blpk_pkg::KIND_BUTTON, 4'd0, 1'b1, 2'd0, 16'd0, 32'd10));
    send(mk(blpk_pkg::KIND_TICK,   4'd0, 1'b0, 2'd0, 16'd0, 32'd499));
    send(mk(blpk_pkg::KIND_TICK,   4'd0, 1'b0, 2'd0, 16'd0, 32'd500));
    send(mk(blpk_pkg::KIND_BUTTON, 4'd0, 1'b0, 2'd0, 16'd0, 32'd600));
    send(mk(blpk_pkg::KIND_BUTTON, 4'd0, 1'b0, 2'd0, 16'd0, 32'd610));
    send(mk(blpk_pkg::KIND_KNOB,   4'd0, 1'b0, 2'd0, 16'h7FFF, 32'd0));
    send(mk(blpk_pkg::KIND_KNOB,   4'd0, 1'b0, 2'd0, 16'h8000, 32'd0));
    send(mk(blpk_pkg::KIND_KNOB,   4'd0, 1'b0, 2'd0, 16'h8000, 32'd0));
    send(mk(blpk_pkg::KIND_KNOB,   4'd0, 1'b0, 2'd3, 16'h0100, 32'd0));
    send(mk(KIND_UNUSED, 4'hF, 1'b1, 2'd3, 16'hFFFF, 32'hFFFF_FFFF));
    // every button pressed just before the time wraps, then one full scan
    for (int i = 0; i < blpk_pkg::BUTTONS; i++)
      send(mk(blpk_pkg::KIND_BUTTON, 4'(i), 1'b1, 2'd0, 16'd0, 32'hFFFF_FF00));
    send(mk(blpk_pkg::KIND_TICK, 4'd0, 1'b0, 2'd0, 16'd0, 32'h0000_00F4));

    // directed: disabled button and knob
    setup(16'd0, 16'hFFFE, 4'hE, 0, 0);
    send(mk(blpk_pkg::KIND_BUTTON, 4'd0, 1'b0, 2'd0, 16'd0, 32'd1000));
    send(mk(blpk_pkg::KIND_KNOB,   4'd0, 1'b0, 2'd0, 16'd5, 32'd1000));
    send(mk(blpk_pkg::KIND_BUTTON, 4'd1, 1'b0, 2'd0, 16'd0, 32'd1000));
    send(mk(blpk_pkg::KIND_TICK,   4'd0, 1'b0, 2'd0, 16'd0, 32'd1000));

    setup(16'd0, 16'hFFFF, 4'hF, 0, 0);
    run_random(20, 40);
    setup(16'hFFFF, 16'($urandom), 4'($urandom), 51, 0);
    run_random(15, 40);
    setup(16'($urandom_range(1, 300)), 16'hFFFF, 4'hF, 0, 51);
    run_random(20, 40);
    setup(16'd0, 16'h0000, 4'h0, 27, 27);
    run_random(8, 10);
    setup(16'($urandom_range(0, 1000)), 16'($urandom), 4'($urandom), 27, 27);
    run_random(15, 40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("PASS button_long_press_and_knob_events_unit");
    end else begin
      $display("FAIL button_long_press_and_knob_events_unit");
    end
    $finish;
  end

endmodule
